// File: rtl/sync_framed_packet_receiver_defines.svh
// Assertion macros shared by the sync framed packet receiver RTL.
`ifndef SYNC_FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define SYNC_FRAMED_PACKET_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFPR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfpr assertion failed");

// Next-cycle implication, checked outside reset.
`define SFPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfpr assertion failed");

`endif

// File: rtl/sfpr_pkg.sv
// Shared types and constants for the sync framed packet receiver.
package sfpr_pkg;

  localparam int PAYLOAD_BYTES_KEPT_DEF = 16;
  localparam int NUM_WORDS              = 4;

  localparam logic [7:0] SYNC_FIRST   = 8'h24;
  localparam logic [7:0] SYNC_SECOND  = 8'hB2;
  localparam logic [7:0] ACK_LENGTH   = 8'd4;
  localparam logic [7:0] HEADER_BYTES = 8'd5;

  localparam logic [2:0] STAT_DATA_OK    = 3'd0;
  localparam logic [2:0] STAT_COLOR_OK   = 3'd1;
  localparam logic [2:0] STAT_ACK        = 3'd2;
  localparam logic [2:0] STAT_CKSUM_ERR  = 3'd3;
  localparam logic [2:0] STAT_LENGTH_ERR = 3'd4;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_TYPE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 3'd4;

  localparam logic [7:0] RST_ACK_TYPE   = 8'd0;
  localparam logic [7:0] RST_DATA_TYPE  = 8'd1;
  localparam logic [7:0] RST_COLOR_TYPE = 8'd2;
  localparam logic [7:0] RST_MIN_LENGTH = 8'd6;
  localparam logic [7:0] RST_MAX_LENGTH = 8'd64;

  typedef struct packed {
    logic [7:0] ack_type_code;
    logic [7:0] data_type_code;
    logic [7:0] color_type_code;
    logic [7:0] min_frame_length;
    logic [7:0] max_frame_length;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                  frame_status;
    logic [7:0]                  sender_id;
    logic [7:0]                  frame_type;
    logic [7:0]                  frame_length;
    logic [NUM_WORDS-1:0][31:0]  payload_word;
  } frame_result_t;

endpackage

// File: rtl/sfpr_cfg_regs.sv
// Configuration register file with write decode and reset values.
module sfpr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sfpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output sfpr_pkg::cfg_t                cfg
);
  import sfpr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_type_code    <= RST_ACK_TYPE;
      cfg.data_type_code   <= RST_DATA_TYPE;
      cfg.color_type_code  <= RST_COLOR_TYPE;
      cfg.min_frame_length <= RST_MIN_LENGTH;
      cfg.max_frame_length <= RST_MAX_LENGTH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ACK_TYPE:   cfg.ack_type_code    <= cfg_data;
        REG_DATA_TYPE:  cfg.data_type_code   <= cfg_data;
        REG_COLOR_TYPE: cfg.color_type_code  <= cfg_data;
        REG_MIN_LENGTH: cfg.min_frame_length <= cfg_data;
        REG_MAX_LENGTH: cfg.max_frame_length <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/sfpr_parser.sv
// Per-byte frame parser: sync hunt, header latch, payload store and checksum.
module sfpr_parser #(
  parameter int PAYLOAD_BYTES_KEPT = sfpr_pkg::PAYLOAD_BYTES_KEPT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  logic [7:0]              rx_byte,
  input  sfpr_pkg::cfg_t          cfg,
  output logic                    result_valid,
  output sfpr_pkg::frame_result_t result
);
  import sfpr_pkg::*;

  localparam int IDX_W = (PAYLOAD_BYTES_KEPT > 1) ? $clog2(PAYLOAD_BYTES_KEPT) : 1;
  localparam logic [7:0] KEEP_COUNT = 8'(PAYLOAD_BYTES_KEPT);

  typedef enum logic [2:0] {
    PH_HUNT, PH_ID, PH_TYPE, PH_LEN, PH_PAYLOAD, PH_CHECK
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] byte_position, position_next;
  logic [7:0] held_sender, sender_next;
  logic [7:0] held_type, type_next;
  logic [7:0] held_length, length_next;
  logic [7:0] running_sum, sum_next;
  logic [7:0] previous_byte;
  logic [7:0] store [PAYLOAD_BYTES_KEPT];

  logic       store_we;
  logic       store_clear;
  logic       emit;
  logic       publish;
  logic [2:0] status;
  logic [8:0] seen_total;

  logic [NUM_WORDS-1:0][31:0] packed_words;

  always_comb begin
    phase_next    = phase;
    position_next = byte_position;
    sender_next   = held_sender;
    type_next     = held_type;
    length_next   = held_length;
    sum_next      = running_sum;
    store_we      = 1'b0;
    store_clear   = 1'b0;
    emit          = 1'b0;
    publish       = 1'b0;
    status        = STAT_DATA_OK;
    seen_total    = {1'b0, byte_position + 8'd1} + {1'b0, HEADER_BYTES};

    unique case (phase)
      PH_ID: begin
        sender_next = rx_byte;
        phase_next  = PH_TYPE;
      end
      PH_TYPE: begin
        type_next  = rx_byte;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        length_next = rx_byte;
        // length limit is checked before anything else
        if (rx_byte > cfg.max_frame_length) begin
          emit       = 1'b1;
          status     = STAT_LENGTH_ERR;
          phase_next = PH_HUNT;
        end else if (held_type == cfg.ack_type_code && rx_byte == ACK_LENGTH) begin
          emit       = 1'b1;
          status     = STAT_ACK;
          phase_next = PH_HUNT;
        end else if ((held_type == cfg.data_type_code || held_type == cfg.color_type_code)
                     && rx_byte >= cfg.min_frame_length) begin
          sum_next      = held_sender + held_type + rx_byte;
          position_next = '0;
          phase_next    = (rx_byte > HEADER_BYTES) ? PH_PAYLOAD : PH_CHECK;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        store_we      = (byte_position < KEEP_COUNT);
        sum_next      = running_sum + rx_byte;
        position_next = byte_position + 8'd1;
        if (seen_total >= {1'b0, held_length}) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        emit = 1'b1;
        if (rx_byte == running_sum) begin
          publish = 1'b1;
          status  = (held_type == cfg.data_type_code) ? STAT_DATA_OK : STAT_COLOR_OK;
        end else begin
          status = STAT_CKSUM_ERR;
        end
        store_clear   = 1'b1;
        sum_next      = '0;
        position_next = '0;
        phase_next    = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase

    // sync pair restarts the frame after the byte has been handled
    if (previous_byte == SYNC_FIRST && rx_byte == SYNC_SECOND) begin
      store_clear   = 1'b1;
      sum_next      = '0;
      position_next = '0;
      phase_next    = PH_ID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_position <= '0;
      held_sender   <= '0;
      held_type     <= '0;
      held_length   <= '0;
      running_sum   <= '0;
      previous_byte <= '0;
    end else if (in_fire) begin
      phase         <= phase_next;
      byte_position <= position_next;
      held_sender   <= sender_next;
      held_type     <= type_next;
      held_length   <= length_next;
      running_sum   <= sum_next;
      previous_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAYLOAD_BYTES_KEPT; i++) begin
        store[i] <= '0;
      end
    end else if (in_fire) begin
      if (store_clear) begin
        for (int i = 0; i < PAYLOAD_BYTES_KEPT; i++) begin
          store[i] <= '0;
        end
      end else if (store_we) begin
        store[byte_position[IDX_W-1:0]] <= rx_byte;
      end
    end
  end

  // bytes past the kept count read as zero
  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
    for (genvar b = 0; b < 4; b++) begin : g_byte
      if (w * 4 + b < PAYLOAD_BYTES_KEPT) begin : g_kept
        assign packed_words[w][8*b +: 8] = store[w * 4 + b];
      end else begin : g_none
        assign packed_words[w][8*b +: 8] = 8'd0;
      end
    end
  end

  assign result_valid        = in_fire && emit;
  assign result.frame_status = status;
  assign result.sender_id    = held_sender;
  assign result.frame_type   = held_type;
  assign result.frame_length = length_next;
  assign result.payload_word = publish ? packed_words : '0;

endmodule

// File: rtl/sfpr_out_skid.sv
// Output register with a skid stage so input transfers continue under stall.
module sfpr_out_skid (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sfpr_pkg::frame_result_t push_data,
  output logic                    space,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sfpr_pkg::frame_result_t out_data
);
  import sfpr_pkg::*;

  logic          skid_valid;
  frame_result_t skid_data;
  logic          drain;

  assign drain = !out_valid || out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// File: rtl/sync_framed_packet_receiver.sv
// Top level of the sync framed packet receiver.
// Takes one received byte per transfer on the input channel, one every clock
// cycle while in_ready is high. The byte is parsed against the held frame
// state in the cycle it is transferred. A frame result (ack, length error,
// checksum result) appears on the output channel the cycle after the byte that
// completes it when the output register is free; otherwise it waits in the skid
// stage until the output register is taken. The per-byte state update sets the
// rate at one byte per cycle while in_ready is high. Results pass through an
// output register and a one-entry skid stage: in_ready falls only when both
// hold untaken results, so bytes keep flowing while one result waits.
// Configuration writes take effect at the next clock edge and belong between
// frames while no result is pending.
`include "sync_framed_packet_receiver_defines.svh"

module sync_framed_packet_receiver #(
  parameter int PAYLOAD_BYTES_KEPT = sfpr_pkg::PAYLOAD_BYTES_KEPT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sfpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     frame_status,
  output logic [7:0]                     sender_id,
  output logic [7:0]                     frame_type,
  output logic [7:0]                     frame_length,
  output logic [31:0]                    payload_word0,
  output logic [31:0]                    payload_word1,
  output logic [31:0]                    payload_word2,
  output logic [31:0]                    payload_word3
);
  import sfpr_pkg::*;

  cfg_t          cfg;
  logic          in_fire;
  logic          result_valid;
  frame_result_t result;
  frame_result_t out_data;
  logic          fail_result;
  logic          payload_zero;

  assign in_fire = in_valid && in_ready;

  sfpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfpr_parser #(
    .PAYLOAD_BYTES_KEPT (PAYLOAD_BYTES_KEPT)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .rx_byte      (rx_byte),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result       (result)
  );

  sfpr_out_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (result_valid),
    .push_data (result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign frame_status  = out_data.frame_status;
  assign sender_id     = out_data.sender_id;
  assign frame_type    = out_data.frame_type;
  assign frame_length  = out_data.frame_length;
  assign payload_word0 = out_data.payload_word[0];
  assign payload_word1 = out_data.payload_word[1];
  assign payload_word2 = out_data.payload_word[2];
  assign payload_word3 = out_data.payload_word[3];

  assign fail_result  = frame_status == STAT_ACK || frame_status == STAT_CKSUM_ERR ||
                        frame_status == STAT_LENGTH_ERR;
  assign payload_zero = payload_word0 == 32'd0 && payload_word1 == 32'd0 &&
                        payload_word2 == 32'd0 && payload_word3 == 32'd0;

  // a full skid stage implies the output register holds a result too
  `SFPR_ASSERT_IMPLIES(a_skid_behind_out, clk, rst, !in_ready, out_valid)
  // error and ack results never publish payload
  `SFPR_ASSERT_IMPLIES(a_no_payload_on_fail, clk, rst, out_valid && fail_result, payload_zero)
  // a result produced while the output is free shows up on the next cycle
  `SFPR_ASSERT_NEXT(a_result_lands, clk, rst, result_valid && !out_valid, out_valid)

endmodule
